[sv/ltms_pkg.sv]
// Shared types, widths and constants for the light tracker motor step block.
`default_nettype none
package ltms_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned PctW    = 7;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned DiffW   = SampleW + 1;
  // |(sample - low) * 100| is at most 102300, which needs 17 bits
  localparam int unsigned NumW    = 17;
  localparam int unsigned DenW    = SampleW;

  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  // register indexes on the configuration port
  localparam logic [1:0] RegPotLow   = 2'd0;
  localparam logic [1:0] RegPotHigh  = 2'd1;
  localparam logic [1:0] RegPosLower = 2'd2;
  localparam logic [1:0] RegPosUpper = 2'd3;

  // motor mode codes
  localparam logic [ModeW-1:0] ModeStop = 2'd0;
  localparam logic [ModeW-1:0] ModeFwd  = 2'd1;
  localparam logic [ModeW-1:0] ModeRev  = 2'd2;

  // light difference bands
  localparam logic signed [DiffW-1:0] DeadZone   = 11'sd5;
  localparam logic signed [DiffW-1:0] BandWide   = 11'sd50;
  localparam logic signed [DiffW-1:0] BandNarrow = 11'sd25;

  localparam logic [DutyW-1:0] SpeedFast = 8'd255;
  localparam logic [DutyW-1:0] SpeedMid  = 8'd150;
  localparam logic [DutyW-1:0] SpeedSlow = 8'd100;

  localparam logic [PctW-1:0] PctFull   = 7'd100;
  localparam logic [PctW-1:0] PosTop    = 7'd99;
  localparam logic [PctW-1:0] PosBottom = 7'd1;

  typedef struct packed {
    logic [SampleW-1:0] light_a;
    logic [SampleW-1:0] light_b;
    logic [SampleW-1:0] pot_sample;
  } in_item_t;

  typedef struct packed {
    logic [ModeW-1:0] motor_mode;
    logic [DutyW-1:0] pwm_target;
    logic             soft_start;
    logic [PctW-1:0]  position_pct;
    logic             command_taken;
  } out_item_t;

  typedef struct packed {
    logic             fwd;
    logic [DutyW-1:0] speed;
  } drive_state_t;

  typedef struct packed {
    logic [PctW-1:0] lower;
    logic [PctW-1:0] upper;
  } limits_t;

  typedef struct packed {
    out_item_t    item;
    drive_state_t next_state;
  } drive_result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

[sv/light_tracker_motor_step.sv]
// Top level of the light tracker motor step: register file, sequencer, output register.
`default_nettype none
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ---------------------------------
//  in        sink       in_valid_i / in_ready_o   in_data_i  (light_a, light_b, pot)
//  out       source     out_valid_o / out_ready_i out_data_o (mode, pwm, soft, pos,
//                                                  command_taken)
//  config    APB slave  psel/penable/pready       4 registers at byte 0, 4, 8, 12
//
//  A request goes from acceptance to a loaded result in steps: form the scaled
//  numerator, divide in the restoring divider (one quotient bit per cycle), wait
//  for the divider's done flag, then decide.
//  Reset clears the drive state to forward at speed 0 and the registers to their
//  calibration defaults; no clearing pass is needed.
//  in_ready_o is high whenever the sequencer is idle, even while a result waits
//  in the output register; a finished request waits in the decide step until that
//  register is free, so a stalled output stalls at most one request behind it.
//
module light_tracker_motor_step (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  ltms_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output ltms_pkg::out_item_t              out_data_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [ltms_pkg::ApbAddrW-1:0]     paddr,
  input  wire [ltms_pkg::ApbDataW-1:0]     pwdata,
  output logic [ltms_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);
  import ltms_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_OUT
  } state_e;

  // configuration registers
  logic [SampleW-1:0] pot_low_q;
  logic [SampleW-1:0] pot_high_q;
  limits_t            limits_q;
  logic               cfg_wr;

  // sequencer and datapath registers
  state_e       state_q;
  in_item_t     item_q;
  logic         neg_q;
  logic         den_zero_q;
  drive_state_t drive_q;
  logic         out_valid_q;
  out_item_t    out_data_q;

  // numerator/denominator forming
  logic signed [DiffW-1:0]  num_diff;
  logic signed [DiffW-1:0]  den_diff;
  logic signed [NumW:0]     num_prod;
  logic [NumW-1:0]          num_mag;
  logic [DenW-1:0]          den_mag;
  logic signed [DiffW-1:0]  den_abs;
  logic signed [NumW:0]     num_abs;

  div_status_t      div_stat;
  logic [NumW-1:0]  div_quot;
  logic [PctW-1:0]  pos;
  drive_result_t    drive_res;
  logic             out_free;

  // ---------------------------------------------------------------- APB port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pot_low_q      <= '0;
      pot_high_q     <= '1;
      limits_q.lower <= '0;
      limits_q.upper <= PctFull;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegPotLow:   pot_low_q      <= pwdata[SampleW-1:0];
        RegPotHigh:  pot_high_q     <= pwdata[SampleW-1:0];
        RegPosLower: limits_q.lower <= pwdata[PctW-1:0];
        RegPosUpper: limits_q.upper <= pwdata[PctW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegPotLow:   prdata = ApbDataW'(pot_low_q);
      RegPotHigh:  prdata = ApbDataW'(pot_high_q);
      RegPosLower: prdata = ApbDataW'(limits_q.lower);
      RegPosUpper: prdata = ApbDataW'(limits_q.upper);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------- position scaling
  // Form |(pot - low) * 100| and |high - low|; the divider works on magnitudes
  // and the sign of the true quotient decides the clamp at zero.
  always_comb begin
    num_diff = $signed({1'b0, item_q.pot_sample}) - $signed({1'b0, pot_low_q});
    den_diff = $signed({1'b0, pot_high_q}) - $signed({1'b0, pot_low_q});
    num_prod = $signed({{(NumW+1-DiffW){num_diff[DiffW-1]}}, num_diff}) * 18'sd100;
    num_abs  = num_prod[NumW] ? -num_prod : num_prod;
    den_abs  = den_diff[DiffW-1] ? -den_diff : den_diff;
    num_mag  = num_abs[NumW-1:0];
    den_mag  = den_abs[DenW-1:0];
  end

  ltms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_PREP),
    .dividend_i (num_mag),
    .divisor_i  (den_mag),
    .status_o   (div_stat),
    .quot_o     (div_quot)
  );

  // clamp: a negative quotient or a zero span gives 0, anything above full scale gives 100
  always_comb begin
    if (den_zero_q || neg_q) begin
      pos = '0;
    end else if (div_quot > NumW'(PctFull)) begin
      pos = PctFull;
    end else begin
      pos = div_quot[PctW-1:0];
    end
  end

  ltms_drive u_drive (
    .item_i   (item_q),
    .pos_i    (pos),
    .limits_i (limits_q),
    .state_i  (drive_q),
    .result_o (drive_res)
  );

  // ---------------------------------------------------------- sequencer
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      neg_q       <= 1'b0;
      den_zero_q  <= 1'b0;
      drive_q.fwd <= 1'b1;
      drive_q.speed <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // drop the output once it is taken, unless the decide step loads the next one
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          neg_q      <= num_prod[NumW] ^ den_diff[DiffW-1];
          den_zero_q <= (den_diff == '0);
          state_q    <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register can take the result
          if (out_free) begin
            drive_q     <= drive_res.next_state;
            out_data_q  <= drive_res.item;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------- assertions
  a_idle_not_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_stat.busy)
    else $error("input ready while the divider is still busy");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  a_mode_matches_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.pwm_target == '0) == (out_data_o.motor_mode == ModeStop)))
    else $error("motor mode disagrees with duty target");

  a_soft_start_driving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.soft_start) |->
      (out_data_o.command_taken && out_data_o.pwm_target != '0))
    else $error("soft start flagged without a taken drive command");

endmodule
`default_nettype wire

[sv/ltms_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module ltms_div (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire [ltms_pkg::NumW-1:0]   dividend_i,
  input  wire [ltms_pkg::DenW-1:0]   divisor_i,
  output ltms_pkg::div_status_t      status_o,
  output logic [ltms_pkg::NumW-1:0]  quot_o
);
  import ltms_pkg::*;

  localparam int unsigned CntW = $clog2(NumW);
  localparam logic [CntW-1:0] LastStep = CntW'(NumW - 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   shifted;
  logic [DenW:0]   diff;
  logic            fits;

  always_comb begin
    shifted = {rem_q, quot_q[NumW-1]};
    diff    = shifted - {1'b0, den_q};
    fits    = (shifted >= {1'b0, den_q});
    quot_d  = quot_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DenW-1:0] : shifted[DenW-1:0];
      quot_d = {quot_q[NumW-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule
`default_nettype wire

[sv/ltms_drive.sv]
// Band decode, position limits and soft start decision for one item.
`default_nettype none
module ltms_drive (
  input  ltms_pkg::in_item_t        item_i,
  input  wire [ltms_pkg::PctW-1:0]  pos_i,
  input  ltms_pkg::limits_t         limits_i,
  input  ltms_pkg::drive_state_t    state_i,
  output ltms_pkg::drive_result_t   result_o
);
  import ltms_pkg::*;

  logic signed [DiffW-1:0] diff;
  logic signed [DiffW-1:0] mag;
  logic                    fwd;
  logic [DutyW-1:0]        speed;
  logic [DutyW-1:0]        prev_speed;
  logic                    taken;
  logic                    ramp;
  logic                    blocked;
  drive_state_t            nxt;

  always_comb begin
    diff       = $signed({1'b0, item_i.light_a}) - $signed({1'b0, item_i.light_b});
    mag        = diff[DiffW-1] ? -diff : diff;
    fwd        = 1'b1;
    speed      = '0;
    prev_speed = state_i.speed;
    taken      = 1'b1;
    ramp       = 1'b0;
    blocked    = 1'b0;
    nxt        = state_i;
    if (mag < DeadZone) begin
      nxt.speed = '0;
    end else begin
      if (diff < -BandWide) begin
        speed = SpeedFast;
      end else if (diff > -BandWide && diff < -BandNarrow) begin
        speed = SpeedMid;
      end else if (diff > -BandNarrow && diff < 0) begin
        speed = SpeedSlow;
      end else if (diff > 0 && diff < BandNarrow) begin
        fwd   = 1'b0;
        speed = SpeedSlow;
      end else if (diff > BandNarrow && diff < BandWide) begin
        fwd   = 1'b0;
        speed = SpeedMid;
      end else if (diff > BandWide) begin
        fwd   = 1'b0;
        speed = SpeedFast;
      end else begin
        // band gap: hold the previous drive
        taken = 1'b0;
      end
      if (taken) begin
        blocked = fwd ? (pos_i > limits_i.upper || pos_i > PosTop)
                      : (pos_i < limits_i.lower || pos_i < PosBottom);
        if (blocked) begin
          nxt.speed = '0;
        end else begin
          if (state_i.fwd != fwd) begin
            nxt.fwd    = fwd;
            prev_speed = '0;
          end
          ramp      = (prev_speed != speed);
          nxt.speed = speed;
        end
      end
    end

    result_o.next_state         = nxt;
    result_o.item.motor_mode    = (nxt.speed == '0) ? ModeStop : (nxt.fwd ? ModeFwd : ModeRev);
    result_o.item.pwm_target    = nxt.speed;
    result_o.item.soft_start    = ramp;
    result_o.item.position_pct  = pos_i;
    result_o.item.command_taken = taken;
  end

endmodule
`default_nettype wire
